@@ rtl/mahsd_pkg.sv @@
`timescale 1ns / 1ps

package mahsd_pkg;

   localparam int unsigned MaxWindow   = 65536;
   localparam int unsigned WindowWidth = 17;
   localparam int unsigned CountWidth  = 17;
   localparam int unsigned SkipWidth   = 16;

   localparam logic [WindowWidth-1:0] WinMax      = WindowWidth'(MaxWindow);
   localparam logic [WindowWidth-1:0] WindowReset = WindowWidth'(65536);

   localparam logic [7:0] SyncByte    = 8'hFF;
   localparam logic [2:0] SyncTopBits = 3'b111;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_SYNC = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   // raw version codes
   localparam logic [1:0] VER_25 = 2'd0;
   localparam logic [1:0] VER_2  = 2'd2;
   localparam logic [1:0] VER_1  = 2'd3;

   // raw layer codes
   localparam logic [1:0] LAYER_RSVD = 2'd0;
   localparam logic [1:0] LAYER_3    = 2'd1;
   localparam logic [1:0] LAYER_2    = 2'd2;
   localparam logic [1:0] LAYER_1    = 2'd3;

   localparam logic [1:0] CHM_JOINT = 2'd1;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_SEARCH  = 5'b00010,
      PH_SEARCHF = 5'b00100,
      PH_HDR3    = 5'b01000,
      PH_HDR4    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  version_code;
      logic [1:0]  layer_code;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic        padding_bit;
      logic [1:0]  stereo_mode;
      logic [1:0]  joint_ext;
      logic [1:0]  emphasis;
      logic [2:0]  flag_bits;
   } hdr_fields_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SkipWidth-1:0] skipped_bytes;
      hdr_fields_type       fields;
   } rsp_type;

   // rows: v1 L1, v1 L2, v1 L3, v2/v2.5 L1, v2/v2.5 L2 and L3
   localparam logic [8:0] KbpsTable [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   // rows: v1, v2, v2.5
   localparam logic [15:0] HzTable [3][4] = '{
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd11025, 16'd12000, 16'd8000, 16'd0}
   };

   function automatic logic [8:0] kbps_lookup(input logic [1:0] ver,
                                              input logic [1:0] lay,
                                              input logic [3:0] idx);
      logic [8:0] rate;
      rate = '0;
      if (ver == VER_1) begin
         unique case (lay)
            LAYER_1: rate = KbpsTable[0][idx];
            LAYER_2: rate = KbpsTable[1][idx];
            LAYER_3: rate = KbpsTable[2][idx];
            default: rate = '0;
         endcase
      end else if (ver == VER_2 || ver == VER_25) begin
         unique case (lay) inside
            LAYER_1:          rate = KbpsTable[3][idx];
            LAYER_2, LAYER_3: rate = KbpsTable[4][idx];
            default:          rate = '0;
         endcase
      end
      return rate;
   endfunction

   function automatic logic [15:0] hz_lookup(input logic [1:0] ver,
                                             input logic [1:0] lay,
                                             input logic [1:0] idx);
      logic [15:0] rate;
      rate = '0;
      if (lay != LAYER_RSVD) begin
         unique case (ver)
            VER_1:   rate = HzTable[0][idx];
            VER_2:   rate = HzTable[1][idx];
            VER_25:  rate = HzTable[2][idx];
            default: rate = '0;
         endcase
      end
      return rate;
   endfunction

endpackage

@@ rtl/mahsd_field_decode.sv @@
`timescale 1ns / 1ps

module mahsd_field_decode (
   input  logic [23:0]                header,
   output mahsd_pkg::hdr_fields_type  fields
);
   import mahsd_pkg::*;

   // header holds the three bytes after the 0xff, first one on top
   always_comb begin
      fields.version_code   = header[20:19];
      fields.layer_code     = header[18:17];
      fields.bitrate_kbps   = kbps_lookup(header[20:19], header[18:17], header[15:12]);
      fields.sample_rate_hz = hz_lookup(header[20:19], header[18:17], header[11:10]);
      fields.padding_bit    = header[9];
      fields.stereo_mode    = header[7:6];
      fields.joint_ext      = (header[7:6] == CHM_JOINT) ? header[5:4] : 2'd0;
      fields.emphasis       = header[1:0];
      fields.flag_bits      = {header[2], header[3], header[16]};
   end

endmodule

@@ rtl/mahsd_sync_fsm.sv @@
`timescale 1ns / 1ps

module mahsd_sync_fsm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  mahsd_pkg::req_type                   req,
   input  logic [mahsd_pkg::WindowWidth-1:0]    window,
   output logic                                 res_valid,
   output mahsd_pkg::rsp_type                   res
);
   import mahsd_pkg::*;

   phase_type              phase_ff, phase_in, cur_phase;
   logic [CountWidth-1:0]  cnt_ff, cnt_in, cur_cnt;
   logic [CountWidth:0]    cnt_next;
   logic [SkipWidth-1:0]   offset_ff, offset_in;
   logic [7:0]             hdr_hi_ff, hdr_hi_in;
   logic [7:0]             hdr_mid_ff, hdr_mid_in;
   logic                   show_fields;
   hdr_fields_type         dec_fields;

   mahsd_field_decode u_decode (
      .header ({hdr_hi_ff, hdr_mid_ff, req.data_byte}),
      .fields (dec_fields)
   );

   always_comb begin
      cur_phase   = req.first_byte ? PH_SEARCH : phase_ff;
      cur_cnt     = req.first_byte ? '0 : cnt_ff;
      cnt_next    = {1'b0, cur_cnt} + (CountWidth+1)'(1);
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      offset_in   = offset_ff;
      hdr_hi_in   = hdr_hi_ff;
      hdr_mid_in  = hdr_mid_ff;
      res_valid   = 1'b0;
      show_fields = 1'b0;
      res.status        = STATUS_OK;
      res.skipped_bytes = '0;
      if (step_en) begin
         phase_in  = cur_phase;
         cnt_in    = cur_cnt;
         offset_in = req.first_byte ? '0 : offset_ff;
         unique case (cur_phase) inside
            PH_SEARCH, PH_SEARCHF: begin
               if (cur_phase == PH_SEARCHF && req.data_byte[7:5] == SyncTopBits &&
                   cur_cnt < window) begin
                  // sync pair found, 0xff sat one byte back
                  offset_in = cur_cnt[SkipWidth-1:0] - SkipWidth'(1);
                  hdr_hi_in = req.data_byte;
                  phase_in  = PH_HDR3;
                  if (req.last_byte) begin
                     phase_in          = PH_IDLE;
                     res_valid         = 1'b1;
                     res.status        = STATUS_SHORT;
                     res.skipped_bytes = cur_cnt[SkipWidth-1:0] - SkipWidth'(1);
                  end
               end else begin
                  phase_in = (req.data_byte == SyncByte) ? PH_SEARCHF : PH_SEARCH;
                  cnt_in   = cnt_next[CountWidth-1:0];
                  if (cnt_next >= {1'b0, window} || req.last_byte) begin
                     phase_in   = PH_IDLE;
                     res_valid  = 1'b1;
                     res.status = STATUS_NO_SYNC;
                  end
               end
            end
            PH_HDR3: begin
               hdr_mid_in = req.data_byte;
               phase_in   = PH_HDR4;
               if (req.last_byte) begin
                  phase_in          = PH_IDLE;
                  res_valid         = 1'b1;
                  res.status        = STATUS_SHORT;
                  res.skipped_bytes = offset_ff;
               end
            end
            PH_HDR4: begin
               phase_in          = PH_IDLE;
               res_valid         = 1'b1;
               show_fields       = 1'b1;
               res.skipped_bytes = offset_ff;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      res.fields = show_fields ? dec_fields : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         offset_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_hi_ff  <= hdr_hi_in;
      hdr_mid_ff <= hdr_mid_in;
   end

   a_result_goes_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> phase_ff == PH_IDLE)
      else $error("phase not idle after a result");

   a_header_sync_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HDR3 || phase_ff == PH_HDR4) |-> hdr_hi_ff[7:5] == SyncTopBits)
      else $error("header held without sync bits");

   a_no_step_no_change: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(cnt_ff))
      else $error("state moved without a step");

endmodule

@@ rtl/mpeg_audio_header_sync_decoder_core.sv @@
`timescale 1ns / 1ps

// channel   ports                                   direction
// req       req_valid/req_ready, data/first/last    in, one stream byte per transfer
// rsp       rsp_valid/rsp_ready, decoded fields     out, one result per header or status
// csr       csr_wr_en, csr_wr_data                  in, search window, no read-back
//
// one byte per cycle sustained while no result stalls; a result is registered once its byte is taken
// the path is input register -> sync fsm and table decode -> result register
// synchronous active-high reset: idle, window 65536, both registers empty
// a stalled result holds the fsm; the input register still takes one more byte
// req_ready falls only when both registers are full and rsp_ready is low

module mpeg_audio_header_sync_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_first_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [mahsd_pkg::SkipWidth-1:0]     rsp_skipped_bytes,
   output logic [1:0]                          rsp_version_code,
   output logic [1:0]                          rsp_layer_code,
   output logic [8:0]                          rsp_bitrate_kbps,
   output logic [15:0]                         rsp_sample_rate_hz,
   output logic                                rsp_padding_bit,
   output logic [1:0]                          rsp_stereo_mode,
   output logic [1:0]                          rsp_joint_ext,
   output logic [1:0]                          rsp_emphasis,
   output logic [2:0]                          rsp_flag_bits,
   input  logic                                csr_wr_en,
   input  logic [mahsd_pkg::WindowWidth-1:0]   csr_wr_data
);
   import mahsd_pkg::*;

   logic                    in_vld_ff, in_vld_in;
   req_type                 in_ff, in_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [WindowWidth-1:0]  window_ff, window_in;
   logic                    advance;
   logic                    step_en;
   logic                    res_valid;
   rsp_type                 res;

   assign advance   = !rsp_vld_ff || rsp_ready;
   assign step_en   = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;

   mahsd_sync_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .req       (in_ff),
      .window    (window_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
         in_in     = '{data_byte: req_data_byte, first_byte: req_first_byte,
                       last_byte: req_last_byte};
      end
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (advance) begin
         rsp_vld_in = step_en && res_valid;
         rsp_in     = res;
      end
      window_in = window_ff;
      if (csr_wr_en) begin
         window_in = (csr_wr_data > WinMax) ? WinMax : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         window_ff  <= (WindowReset > WinMax) ? WinMax : WindowReset;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         window_ff  <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_skipped_bytes  = rsp_ff.skipped_bytes;
   assign rsp_version_code   = rsp_ff.fields.version_code;
   assign rsp_layer_code     = rsp_ff.fields.layer_code;
   assign rsp_bitrate_kbps   = rsp_ff.fields.bitrate_kbps;
   assign rsp_sample_rate_hz = rsp_ff.fields.sample_rate_hz;
   assign rsp_padding_bit    = rsp_ff.fields.padding_bit;
   assign rsp_stereo_mode    = rsp_ff.fields.stereo_mode;
   assign rsp_joint_ext      = rsp_ff.fields.joint_ext;
   assign rsp_emphasis       = rsp_ff.fields.emphasis;
   assign rsp_flag_bits      = rsp_ff.fields.flag_bits;

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_ff))
      else $error("held byte lost while result stalled");

   a_no_sync_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.status == STATUS_NO_SYNC |->
         rsp_ff.skipped_bytes == '0 && rsp_ff.fields == '0)
      else $error("no-sync result carries header fields");

   a_reserved_layer_rates: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.fields.layer_code == LAYER_RSVD |->
         rsp_ff.fields.sample_rate_hz == '0 && rsp_ff.fields.bitrate_kbps == '0)
      else $error("reserved layer gave a rate");

endmodule
